// ===== rtl/core/cps_pkg.sv =====
// Package for the soil water retention block: shared control struct,
// register indexes, fixed widths and the exp2 root table function.
// No dependencies.
package cps_pkg;

  typedef struct packed {
    logic v;
    logic inv;
  } cps_ctl_t;

  typedef logic [1:0] cps_cfg_idx_t;

  localparam cps_cfg_idx_t CFG_THETA_S = 2'd0;
  localparam cps_cfg_idx_t CFG_PSI_SAT = 2'd1;
  localparam cps_cfg_idx_t CFG_K_SAT   = 2'd2;
  localparam cps_cfg_idx_t CFG_B_EXP   = 2'd3;

  // integer part of the psi exponent, and ceiling of the k exponent
  localparam int NW = 10;
  localparam int QW = 13;

  localparam logic [32:0] RATIO_MIN = 33'd4295;

  // 2^(2^-idx) in Q1.31, by repeated integer square roots
  function automatic logic [63:0] cps_exp_rom(input int idx);
    logic [63:0] t;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bw;
    t = 64'h1_0000_0000;
    for (int i = 1; i <= idx; i++) begin
      v   = t << 31;
      res = '0;
      bw  = 64'h4000_0000_0000_0000;
      for (int k = 0; k < 32; k++) begin
        if (v >= res + bw) begin
          v   = v - (res + bw);
          res = (res >> 1) + bw;
        end else begin
          res = res >> 1;
        end
        bw = bw >> 2;
      end
      t = res;
    end
    return t;
  endfunction

endpackage

// ===== rtl/core/campbell_psi_and_conductivity.sv =====
// Campbell retention curve: one theta sample in, psi and k out, one request
// per cycle while not stalled. Stages: capture, 32 divider cells, normalize,
// FRACTION_BITS log cells, an exponent stage pair, FRACTION_BITS exp cells,
// a scale stage and the output register. The whole pipeline holds while a
// result waits on out_stall. The user must write layer registers on the cfg
// channel only while no request is in flight; the block does not enforce it.
module campbell_psi_and_conductivity import cps_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [17:0] in_water_content,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_matric_potential,
  output logic [31:0]        out_conductivity,
  output logic               out_invalid_content,
  output logic               out_potential_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int F   = FRACTION_BITS;
  localparam int NLW = F + 6;

  logic [15:0] ts_r;
  logic [31:0] psi_sat_r;
  logic [31:0] k_sat_r;
  logic [15:0] b_r;
  logic        en;
  logic [15:0] ts_eff;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign ts_eff    = (ts_r == 16'd0) ? 16'd1 : ts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r      <= 16'd29491;
      psi_sat_r <= 32'hFFFF_0000;
      k_sat_r   <= 32'd65536;
      b_r       <= 16'd20070;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THETA_S: ts_r      <= cfg_data[15:0];
        CFG_PSI_SAT: psi_sat_r <= cfg_data;
        CFG_K_SAT:   k_sat_r   <= cfg_data;
        CFG_B_EXP:   b_r       <= cfg_data[15:0];
        default:     ts_r      <= ts_r;
      endcase
    end
  end

  // capture
  cps_ctl_t    cap_ctl_r;
  logic        cap_hi_r;
  logic [15:0] cap_rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_ctl_r <= '0;
    end else if (en) begin
      cap_ctl_r <= '{v: in_valid, inv: in_water_content[17]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cap_hi_r  <= in_water_content[16:0] >= {1'b0, ts_eff};
      cap_rem_r <= in_water_content[15:0];
    end
  end

  // divider chain
  cps_ctl_t    dctl [0:32];
  logic        dhi  [0:32];
  logic [15:0] drem [0:32];
  logic [31:0] dq   [0:32];

  assign dctl[0] = cap_ctl_r;
  assign dhi[0]  = cap_hi_r;
  assign drem[0] = cap_rem_r;
  assign dq[0]   = '0;

  for (genvar g = 0; g < 32; g++) begin : g_div
    cps_div_cell u_cell (
      .clk, .rst_n, .en, .ts(ts_eff),
      .ctl_i(dctl[g]),   .hi_i(dhi[g]),   .rem_i(drem[g]),   .q_i(dq[g]),
      .ctl_o(dctl[g+1]), .hi_o(dhi[g+1]), .rem_o(drem[g+1]), .q_o(dq[g+1])
    );
  end

  // normalize
  logic [32:0] ratio;
  logic [4:0]  msb;
  cps_ctl_t    nrm_ctl_r;
  logic [31:0] nrm_m_r;
  logic [5:0]  nrm_ip_r;
  logic [31:0] m_nxt;
  logic [5:0]  ip_nxt;

  always_comb begin
    ratio = dhi[32] ? 33'h1_0000_0000 : {1'b0, dq[32]};
    if (ratio < RATIO_MIN) ratio = RATIO_MIN;
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (ratio[i]) msb = 5'(i);
    end
    if (ratio[32]) begin
      m_nxt  = 32'h8000_0000;
      ip_nxt = '0;
    end else begin
      m_nxt  = ratio[31:0] << (5'd31 - msb);
      ip_nxt = 6'd32 - {1'b0, msb};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_ctl_r <= '0;
    end else if (en) begin
      nrm_ctl_r <= dctl[32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm_m_r  <= m_nxt;
      nrm_ip_r <= ip_nxt;
    end
  end

  // log2 chain
  cps_ctl_t     lctl [0:F];
  logic [31:0]  lm   [0:F];
  logic [F-1:0] lfr  [0:F];
  logic [5:0]   lip  [0:F];

  assign lctl[0] = nrm_ctl_r;
  assign lm[0]   = nrm_m_r;
  assign lfr[0]  = '0;
  assign lip[0]  = nrm_ip_r;

  for (genvar g = 0; g < F; g++) begin : g_log
    cps_log_cell #(.FW(F)) u_cell (
      .clk, .rst_n, .en,
      .ctl_i(lctl[g]),   .m_i(lm[g]),   .frac_i(lfr[g]),   .ip_i(lip[g]),
      .ctl_o(lctl[g+1]), .m_o(lm[g+1]), .frac_o(lfr[g+1]), .ip_o(lip[g+1])
    );
  end

  // -log2(ratio)
  cps_ctl_t       nl_ctl_r;
  logic [NLW-1:0] nl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nl_ctl_r <= '0;
    end else if (en) begin
      nl_ctl_r <= lctl[F];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nl_r <= (NLW'(lip[F]) << F) - NLW'(lfr[F]);
    end
  end

  // exponents
  logic [17:0]       kcoef;
  logic [NLW+15:0]   pe;
  logic [NLW+17:0]   pk;
  logic [F-1:0]      ek_lo;
  cps_ctl_t          ex_ctl_r;
  logic [F-1:0]      ex_fp_r;
  logic [F-1:0]      ex_fk_r;
  logic [NW-1:0]     ex_n_r;
  logic [QW-1:0]     ex_q_r;

  always_comb begin
    kcoef = 18'd12288 + {1'b0, b_r, 1'b0};
    pe    = {{NLW{1'b0}}, b_r} * {16'd0, nl_r};
    pk    = {{NLW{1'b0}}, kcoef} * {18'd0, nl_r};
    ek_lo = pk[12+F-1:12];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_ctl_r <= '0;
    end else if (en) begin
      ex_ctl_r <= nl_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex_fp_r <= pe[12+F-1:12];
      ex_n_r  <= pe[NLW+15:12+F];
      ex_fk_r <= F'(0) - ek_lo;
      ex_q_r  <= {1'b0, pk[NLW+17:12+F]} + QW'(ek_lo != '0);
    end
  end

  // exp2 chain
  cps_ctl_t      xctl [0:F];
  logic [31:0]   xap  [0:F];
  logic [31:0]   xak  [0:F];
  logic [F-1:0]  xfp  [0:F];
  logic [F-1:0]  xfk  [0:F];
  logic [NW-1:0] xn   [0:F];
  logic [QW-1:0] xq   [0:F];

  assign xctl[0] = ex_ctl_r;
  assign xap[0]  = 32'h8000_0000;
  assign xak[0]  = 32'h8000_0000;
  assign xfp[0]  = ex_fp_r;
  assign xfk[0]  = ex_fk_r;
  assign xn[0]   = ex_n_r;
  assign xq[0]   = ex_q_r;

  for (genvar g = 0; g < F; g++) begin : g_exp
    cps_exp_cell #(.FW(F), .IDX(g + 1)) u_cell (
      .clk, .rst_n, .en,
      .ctl_i(xctl[g]), .ap_i(xap[g]), .ak_i(xak[g]), .fp_i(xfp[g]), .fk_i(xfk[g]),
      .n_i(xn[g]), .q_i(xq[g]),
      .ctl_o(xctl[g+1]), .ap_o(xap[g+1]), .ak_o(xak[g+1]), .fp_o(xfp[g+1]),
      .fk_o(xfk[g+1]), .n_o(xn[g+1]), .q_o(xq[g+1])
    );
  end

  // scale by the saturated values
  logic          psi_neg;
  logic [31:0]   psi_abs;
  logic [63:0]   pprod;
  cps_ctl_t      sc_ctl_r;
  logic [32:0]   sc_mag_r;
  logic [63:0]   sc_k_r;
  logic [NW-1:0] sc_n_r;
  logic [QW-1:0] sc_q_r;

  always_comb begin
    psi_neg = psi_sat_r[31];
    psi_abs = psi_neg ? (~psi_sat_r + 32'd1) : psi_sat_r;
    pprod   = {32'd0, psi_abs} * {32'd0, xap[F]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_ctl_r <= '0;
    end else if (en) begin
      sc_ctl_r <= xctl[F];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_mag_r <= pprod[63:31];
      sc_k_r   <= {32'd0, k_sat_r} * {32'd0, xak[F]};
      sc_n_r   <= xn[F];
      sc_q_r   <= xq[F];
    end
  end

  // shift, saturate, output register
  logic [47:0]   limit;
  logic [47:0]   mag48;
  logic          sat;
  logic [47:0]   psi_nxt;
  logic [QW:0]   ksh;
  logic [31:0]   k_nxt;
  logic          out_valid_r;
  logic [47:0]   psi_r;
  logic [31:0]   k_r;
  logic          inv_r;
  logic          sat_r;

  always_comb begin
    limit = psi_neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    sat   = (sc_n_r >= NW'(48)) || ({15'd0, sc_mag_r} > (limit >> sc_n_r));
    mag48 = sat ? limit : ({15'd0, sc_mag_r} << sc_n_r[5:0]);
    psi_nxt = psi_neg ? (~mag48 + 48'd1) : mag48;
    if (psi_sat_r == 32'd0) begin
      psi_nxt = '0;
      sat     = 1'b0;
    end
    ksh   = {1'b0, sc_q_r} + (QW+1)'(31);
    k_nxt = (ksh >= (QW+1)'(64)) ? 32'd0 : 32'(sc_k_r >> ksh[5:0]);
    if (sc_ctl_r.inv) begin
      psi_nxt = '0;
      sat     = 1'b0;
      k_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sc_ctl_r.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      psi_r <= psi_nxt;
      k_r   <= k_nxt;
      inv_r <= sc_ctl_r.inv;
      sat_r <= sat;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_matric_potential    = signed'(psi_r);
  assign out_conductivity        = k_r;
  assign out_invalid_content     = inv_r;
  assign out_potential_saturated = sat_r;

endmodule

// ===== rtl/core/cps_div_cell.sv =====
// One restoring division step: produces one quotient bit of theta/theta_s.
// Depends on cps_pkg.
module cps_div_cell import cps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [15:0] ts,
  input  cps_ctl_t    ctl_i,
  input  logic        hi_i,
  input  logic [15:0] rem_i,
  input  logic [31:0] q_i,
  output cps_ctl_t    ctl_o,
  output logic        hi_o,
  output logic [15:0] rem_o,
  output logic [31:0] q_o
);

  cps_ctl_t    ctl_r;
  logic        hi_r;
  logic [15:0] rem_r;
  logic [31:0] q_r;
  logic [16:0] rem2;
  logic [16:0] diff;
  logic        ge;
  logic [15:0] rem_nxt;

  always_comb begin
    rem2    = {rem_i, 1'b0};
    diff    = rem2 - {1'b0, ts};
    ge      = rem2 >= {1'b0, ts};
    rem_nxt = ge ? diff[15:0] : rem2[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_r  <= hi_i;
      rem_r <= rem_nxt;
      q_r   <= {q_i[30:0], ge};
    end
  end

  assign ctl_o = ctl_r;
  assign hi_o  = hi_r;
  assign rem_o = rem_r;
  assign q_o   = q_r;

endmodule

// ===== rtl/core/cps_log_cell.sv =====
// One squaring step of the log2 mantissa: yields one fraction bit.
// Depends on cps_pkg.
module cps_log_cell import cps_pkg::*; #(
  parameter int FW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  cps_ctl_t      ctl_i,
  input  logic [31:0]   m_i,
  input  logic [FW-1:0] frac_i,
  input  logic [5:0]    ip_i,
  output cps_ctl_t      ctl_o,
  output logic [31:0]   m_o,
  output logic [FW-1:0] frac_o,
  output logic [5:0]    ip_o
);

  cps_ctl_t      ctl_r;
  logic [31:0]   m_r;
  logic [FW-1:0] frac_r;
  logic [5:0]    ip_r;
  logic [63:0]   sq;
  logic [32:0]   m2;
  logic [31:0]   m_nxt;

  always_comb begin
    sq    = {32'd0, m_i} * {32'd0, m_i};
    m2    = sq[63:31];
    m_nxt = m2[32] ? m2[32:1] : m2[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= m_nxt;
      frac_r <= {frac_i[FW-2:0], m2[32]};
      ip_r   <= ip_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign m_o    = m_r;
  assign frac_o = frac_r;
  assign ip_o   = ip_r;

endmodule

// ===== rtl/core/cps_exp_cell.sv =====
// One exp2 step for both powers: multiplies by 2^(2^-IDX) when that bit is set.
// Depends on cps_pkg (root table, widths).
module cps_exp_cell import cps_pkg::*; #(
  parameter int FW  = 16,
  parameter int IDX = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  cps_ctl_t      ctl_i,
  input  logic [31:0]   ap_i,
  input  logic [31:0]   ak_i,
  input  logic [FW-1:0] fp_i,
  input  logic [FW-1:0] fk_i,
  input  logic [NW-1:0] n_i,
  input  logic [QW-1:0] q_i,
  output cps_ctl_t      ctl_o,
  output logic [31:0]   ap_o,
  output logic [31:0]   ak_o,
  output logic [FW-1:0] fp_o,
  output logic [FW-1:0] fk_o,
  output logic [NW-1:0] n_o,
  output logic [QW-1:0] q_o
);

  localparam logic [63:0] TROM = cps_exp_rom(IDX);
  localparam logic [31:0] TV   = TROM[31:0];

  cps_ctl_t      ctl_r;
  logic [31:0]   ap_r;
  logic [31:0]   ak_r;
  logic [FW-1:0] fp_r;
  logic [FW-1:0] fk_r;
  logic [NW-1:0] n_r;
  logic [QW-1:0] q_r;
  logic [63:0]   pp;
  logic [63:0]   pk;

  always_comb begin
    pp = {32'd0, ap_i} * {32'd0, TV};
    pk = {32'd0, ak_i} * {32'd0, TV};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ap_r <= fp_i[FW-IDX] ? pp[62:31] : ap_i;
      ak_r <= fk_i[FW-IDX] ? pk[62:31] : ak_i;
      fp_r <= fp_i;
      fk_r <= fk_i;
      n_r  <= n_i;
      q_r  <= q_i;
    end
  end

  assign ctl_o = ctl_r;
  assign ap_o  = ap_r;
  assign ak_o  = ak_r;
  assign fp_o  = fp_r;
  assign fk_o  = fk_r;
  assign n_o   = n_r;
  assign q_o   = q_r;

endmodule

// ===== rtl/core/cps_checker.sv =====
// Port-level checks on the result channel of the retention block.
// Bound to campbell_psi_and_conductivity at the end of this file.
module cps_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [47:0] out_matric_potential,
  input logic [31:0]        out_conductivity,
  input logic               out_invalid_content,
  input logic               out_potential_saturated
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("valid result after reset");

  a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid_content |->
      out_matric_potential == 48'sd0 && out_conductivity == 32'd0 &&
      !out_potential_saturated)
    else $error("negative theta gave nonzero outputs");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_potential_saturated |->
      out_matric_potential == 48'sh7FFF_FFFF_FFFF ||
      out_matric_potential == 48'sh8000_0000_0000)
    else $error("saturated psi not at range limit");

endmodule

bind campbell_psi_and_conductivity cps_checker u_cps_checker (.*);
